// ===== rtl/adts_hd_pkg.sv =====
// Shared types and constants for the ADTS header deframer.
`timescale 1ns / 1ps
`default_nettype none

package adts_hd_pkg;

   // result kinds
   localparam logic [1:0] KIND_HEADER    = 2'd0;
   localparam logic [1:0] KIND_PAYLOAD   = 2'd1;
   localparam logic [1:0] KIND_BAD_SYNC  = 2'd2;
   localparam logic [1:0] KIND_TRUNCATED = 2'd3;

   localparam logic [11:0] SYNC_WORD = 12'hFFF;

   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_payload_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        last;
      logic [7:0]  data_byte;
      logic [1:0]  profile;
      logic [3:0]  sample_rate_index;
      logic [2:0]  channel_config;
      logic [12:0] frame_length;
      logic [10:0] buffer_fullness;
      logic [2:0]  raw_blocks;
      logic [15:0] crc_word;
      logic [15:0] audio_config;
      logic [8:0]  misc_bits;
   } rsp_payload_type;

endpackage

`default_nettype wire

// ===== rtl/adts_hd_channels.sv =====
// Valid/ready channel interfaces for the deframer input and result streams.
`timescale 1ns / 1ps
`default_nettype none

interface adts_hd_req_if import adts_hd_pkg::*; ();
   logic            valid;
   logic            ready;
   req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

interface adts_hd_rsp_if import adts_hd_pkg::*; ();
   logic            valid;
   logic            ready;
   rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/adts_hd_unpack.sv =====
// Unpacks the seven header bytes and CRC word into a header summary result.
`timescale 1ns / 1ps
`default_nettype none

module adts_hd_unpack import adts_hd_pkg::*; (
   input  wire logic [55:0]     header_bits,
   input  wire logic [15:0]     crc_bits,
   input  wire logic            last,
   output rsp_payload_type      summary
);

   logic [2:0] audio_object;
   logic [7:0] config_byte0;
   logic [7:0] config_byte1;

   always_comb begin
      // object type is profile plus one, at most 4
      audio_object = {1'b0, header_bits[39:38]} + 3'd1;
      config_byte0 = {2'b00, audio_object, header_bits[37:35]};
      config_byte1 = {header_bits[34], 1'b0, header_bits[32:30], 3'b000};

      summary                   = '0;
      summary.kind              = KIND_HEADER;
      summary.last              = last;
      summary.profile           = header_bits[39:38];
      summary.sample_rate_index = header_bits[37:34];
      summary.channel_config    = header_bits[32:30];
      summary.frame_length      = header_bits[25:13];
      summary.buffer_fullness   = header_bits[12:2];
      summary.raw_blocks        = {1'b0, header_bits[1:0]} + 3'd1;
      // protection_absent set means no CRC word in the frame
      summary.crc_word          = header_bits[40] ? 16'h0000 : crc_bits;
      summary.audio_config      = {config_byte0, config_byte1};
      summary.misc_bits         = {header_bits[43], header_bits[42:41], header_bits[40],
                                   header_bits[33], header_bits[29], header_bits[28],
                                   header_bits[27], header_bits[26]};
   end

endmodule

`default_nettype wire

// ===== rtl/adts_header_deframer_unit.sv =====
// ADTS header deframer: checks sync, unpacks the header and forwards the payload.
//
// Usage: frames arrive on req_if one byte per transaction, with in_last set on
// the final byte. For each frame the block emits one header summary on rsp_if
// (fields, CRC word when present, two-byte AudioSpecificConfig) after the 7th
// byte, or after the 9th when protection_absent is 0, then one payload
// transaction per remaining byte. A sync word other than 0xFFF gives one
// bad-sync result on the second byte and the rest of the frame is dropped
// silently. A frame that ends inside the header gives one truncated result.
// A result is registered and shows on rsp_if in the cycle after the byte that
// causes it is accepted. Throughput: one byte per cycle unless stalled; the state
// update and the field unpack sit between the frame state registers and the single
// result register. Stall: while a result waits on rsp_if, req_if.ready drops
// only if the result is not taken in that cycle; the waiting result holds unchanged.
// Reset (synchronous, active high): returns to the header phase with a zero
// byte count and an empty result register; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none

module adts_header_deframer_unit import adts_hd_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   adts_hd_req_if.sink   req_if,
   adts_hd_rsp_if.source rsp_if
);

   localparam logic [1:0] PH_HEADER  = 2'd0;
   localparam logic [1:0] PH_PAYLOAD = 2'd1;
   localparam logic [1:0] PH_DROP    = 2'd2;

   localparam logic [3:0] HEADER_BYTES    = 4'd7;
   localparam logic [3:0] HEADER_CRC_END  = 4'd9;
   localparam logic [3:0] SYNC_CHECK_BYTE = 4'd2;

   logic [1:0]      phase_ff, phase_in;
   logic [3:0]      count_ff, count_in;
   logic [55:0]     header_ff, header_in;
   logic [15:0]     crc_ff, crc_in;
   logic            rsp_valid_ff, rsp_valid_in;
   rsp_payload_type rsp_data_ff, rsp_data_in;

   logic            accept;
   logic            byte_last;
   logic [3:0]      count_inc;
   logic            sync_bad;
   logic            header_done;
   rsp_payload_type summary;

   assign accept    = req_if.valid && req_if.ready;
   assign byte_last = req_if.payload.in_last;

   assign req_if.ready   = !rsp_valid_ff || rsp_if.ready;
   assign rsp_if.valid   = rsp_valid_ff;
   assign rsp_if.payload = rsp_data_ff;

   always_comb begin
      if (count_ff < HEADER_BYTES) begin
         header_in = {header_ff[47:0], req_if.payload.in_byte};
         crc_in    = crc_ff;
      end else begin
         header_in = header_ff;
         crc_in    = {crc_ff[7:0], req_if.payload.in_byte};
      end
      count_inc   = count_ff + 4'd1;
      sync_bad    = (count_inc == SYNC_CHECK_BYTE) && (header_in[15:4] != SYNC_WORD);
      header_done = ((count_inc == HEADER_BYTES) && header_in[40]) ||
                    ((count_inc == HEADER_CRC_END) && !header_in[40]);
   end

   adts_hd_unpack u_unpack (
      .header_bits (header_in),
      .crc_bits    (crc_in),
      .last        (byte_last),
      .summary     (summary)
   );

   always_comb begin
      phase_in     = phase_ff;
      count_in     = count_ff;
      rsp_valid_in = 1'b0;
      rsp_data_in  = '0;
      case (phase_ff)
         PH_PAYLOAD: begin
            rsp_valid_in          = 1'b1;
            rsp_data_in.kind      = KIND_PAYLOAD;
            rsp_data_in.last      = byte_last;
            rsp_data_in.data_byte = req_if.payload.in_byte;
         end
         PH_DROP: begin
            rsp_valid_in = 1'b0;
         end
         default: begin
            count_in = count_inc;
            if (sync_bad) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.kind = KIND_BAD_SYNC;
               rsp_data_in.last = byte_last;
               phase_in         = PH_DROP;
            end else if (header_done) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = summary;
               phase_in     = PH_PAYLOAD;
            end else if (byte_last) begin
               rsp_valid_in     = 1'b1;
               rsp_data_in.kind = KIND_TRUNCATED;
               rsp_data_in.last = 1'b1;
            end
         end
      endcase
      // last byte of any frame: restart in the header phase
      if (byte_last) begin
         phase_in = PH_HEADER;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_HEADER;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            phase_ff <= phase_in;
            count_ff <= count_in;
         end
         if (req_if.ready) begin
            rsp_valid_ff <= accept && rsp_valid_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         header_ff <= header_in;
         crc_ff    <= crc_in;
      end
      if (req_if.ready) begin
         rsp_data_ff <= rsp_data_in;
      end
   end

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_DROP) |=> !rsp_if.valid)
      else $error("dropped byte produced a result");

   a_payload_forward: assert property (@(posedge clock) disable iff (reset)
      accept && (phase_ff == PH_PAYLOAD) |=>
         rsp_if.valid && (rsp_if.payload.kind == KIND_PAYLOAD))
      else $error("payload byte not forwarded");

   a_frame_restart: assert property (@(posedge clock) disable iff (reset)
      accept && byte_last |=> (phase_ff == PH_HEADER) && (count_ff == 4'd0))
      else $error("frame end did not restart header phase");

   // the count holds at its final header value through the payload
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= HEADER_CRC_END)
      else $error("header byte count out of range");

   a_header_last: assert property (@(posedge clock) disable iff (reset)
      rsp_if.valid && (rsp_if.payload.kind == KIND_TRUNCATED) |-> rsp_if.payload.last)
      else $error("truncated result without last");

endmodule

`default_nettype wire

// ===== dv/adts_header_deframer_unit_test.sv =====
// Self-checking testbench for the ADTS header deframer: directed frames, then random frames.
`timescale 1ns / 1ps

module adts_header_deframer_unit_test import adts_hd_pkg::*; ();

   localparam int unsigned CYCLE_LIMIT  = 300000;
   localparam int unsigned PHASE_ITEMS  = 190;

   typedef enum logic [1:0] {FRAME_HEADER, FRAME_PAYLOAD, FRAME_DROP} frame_phase_type;
   typedef enum logic [1:0] {ROW_PREDICT, ROW_SILENT, ROW_RESULT} row_mode_type;

   typedef struct {
      logic [7:0]   in_byte;
      logic         in_last;
      row_mode_type mode;
      logic [1:0]   kind;
      logic         last;
      logic [7:0]   data;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   adts_hd_req_if req_chan ();
   adts_hd_rsp_if rsp_chan ();

   adts_header_deframer_unit u_top (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_chan),
      .rsp_if (rsp_chan)
   );

   always #5 clock = ~clock;

   // deframer state as the predictor sees it
   frame_phase_type frame_phase;
   logic [3:0]      hdr_count;
   logic [55:0]     hdr_bits;
   logic [15:0]     crc_bits;

   rsp_payload_type header_expect_q[$];

   int unsigned src_idle_pct = 0;
   int unsigned rsp_stall_pct = 0;
   int unsigned cycle_cnt = 0;
   int unsigned err_cnt = 0;
   int unsigned item_cnt = 0;
   int unsigned frame_cnt = 0;
   int unsigned rsp_cnt = 0;
   int unsigned kind_cnt[4] = '{0, 0, 0, 0};

   int unsigned idle_pct_tbl[4]  = '{0, 86, 0, 12};
   int unsigned stall_pct_tbl[4] = '{0, 0, 86, 12};

   stim_row_type directed_rows[28] = '{
      // single-byte frame ends inside the header
      '{8'hFF, 1'b1, ROW_RESULT, KIND_TRUNCATED, 1'b1, 8'h00},
      // bad sync on a byte that also closes the frame
      '{8'h00, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b1, ROW_RESULT, KIND_BAD_SYNC,  1'b1, 8'h00},
      // bad sync mid-frame, rest of the frame is dropped
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hE0, 1'b0, ROW_RESULT, KIND_BAD_SYNC,  1'b0, 8'h00},
      '{8'h12, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h34, 1'b1, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      // good sync, frame ends on the third byte
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hF1, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b1, ROW_RESULT, KIND_TRUNCATED, 1'b1, 8'h00},
      // all-ones header without CRC, then two payload bytes
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_PREDICT, KIND_HEADER,   1'b0, 8'h00},
      '{8'hFF, 1'b0, ROW_RESULT, KIND_PAYLOAD,   1'b0, 8'hFF},
      '{8'h00, 1'b1, ROW_RESULT, KIND_PAYLOAD,   1'b1, 8'h00},
      // header with all fields after the sync zero and a CRC, header closes the frame
      '{8'hFF, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hF0, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'h00, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hAB, 1'b0, ROW_SILENT, KIND_HEADER,    1'b0, 8'h00},
      '{8'hCD, 1'b1, ROW_PREDICT, KIND_HEADER,   1'b0, 8'h00}
   };

   function automatic void clear_frame();
      frame_phase = FRAME_HEADER;
      hdr_count   = 4'd0;
      hdr_bits    = '0;
      crc_bits    = '0;
   endfunction

   // advance the deframer state by one byte and build the result it causes
   function automatic void deframe_byte(input logic [7:0] b, input logic l,
                                        output bit produced, output rsp_payload_type r);
      logic       prot_absent;
      logic [1:0] prof;
      logic [3:0] sri;
      logic [2:0] chan;
      logic [4:0] obj_type;
      r = '0;
      produced = 1'b0;
      item_cnt++;
      if (frame_phase == FRAME_DROP) begin
         if (l) clear_frame();
      end else if (frame_phase == FRAME_PAYLOAD) begin
         produced    = 1'b1;
         r.kind      = KIND_PAYLOAD;
         r.last      = l;
         r.data_byte = b;
         if (l) clear_frame();
      end else begin
         if (hdr_count < 4'd7) hdr_bits = {hdr_bits[47:0], b};
         else crc_bits = {crc_bits[7:0], b};
         hdr_count   = hdr_count + 4'd1;
         prot_absent = hdr_bits[40];
         produced    = 1'b1;
         r.last      = l;
         if (hdr_count == 4'd2 && hdr_bits[15:4] != SYNC_WORD) begin
            r.kind = KIND_BAD_SYNC;
            if (l) clear_frame();
            else frame_phase = FRAME_DROP;
         end else if ((hdr_count == 4'd7 && prot_absent) ||
                      (hdr_count == 4'd9 && !prot_absent)) begin
            prof     = hdr_bits[39:38];
            sri      = hdr_bits[37:34];
            chan     = hdr_bits[32:30];
            obj_type = {3'b000, prof} + 5'd1;
            r.kind              = KIND_HEADER;
            r.profile           = prof;
            r.sample_rate_index = sri;
            r.channel_config    = chan;
            r.frame_length      = hdr_bits[25:13];
            r.buffer_fullness   = hdr_bits[12:2];
            r.raw_blocks        = {1'b0, hdr_bits[1:0]} + 3'd1;
            r.crc_word          = prot_absent ? 16'h0000 : crc_bits;
            r.audio_config      = {obj_type, sri[3:1], sri[0], 1'b0, chan, 3'b000};
            r.misc_bits         = {hdr_bits[43], hdr_bits[42:41], hdr_bits[40],
                                   hdr_bits[33], hdr_bits[29], hdr_bits[28],
                                   hdr_bits[27], hdr_bits[26]};
            if (l) clear_frame();
            else frame_phase = FRAME_PAYLOAD;
         end else if (l) begin
            r.kind = KIND_TRUNCATED;
            clear_frame();
         end else begin
            produced = 1'b0;
         end
      end
   endfunction

   task automatic report_mismatch(input string what);
      err_cnt++;
      $display("mismatch at cycle %0d: %s", cycle_cnt, what);
   endtask

   task automatic check_field(input string name, input logic [15:0] got, input logic [15:0] want);
      if (got !== want)
         report_mismatch($sformatf("result %0d field %s got 0x%0h expected 0x%0h",
                                   rsp_cnt, name, got, want));
   endtask

   // drive one byte, wait for the transaction, then predict its result
   task automatic send_item(input logic [7:0] b, input logic l, input row_mode_type mode,
                            input rsp_payload_type typed);
      bit              produced;
      rsp_payload_type pred;
      while (src_idle_pct != 0 && $urandom_range(99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid   <= 1'b1;
      req_chan.payload <= '{in_byte: b, in_last: l};
      do @(posedge clock); while (!req_chan.ready);
      deframe_byte(b, l, produced, pred);
      if (mode == ROW_SILENT) begin
         produced = 1'b0;
      end else if (mode == ROW_RESULT) begin
         produced = 1'b1;
         pred     = typed;
      end
      if (produced) header_expect_q.push_back(pred);
      @(negedge clock);
   endtask

   // hold the sender until every expected result is out, then switch idle and stall mix
   task automatic drain_results(input int unsigned next_idle, input int unsigned next_stall);
      req_chan.valid <= 1'b0;
      do @(posedge clock); while (header_expect_q.size() != 0);
      src_idle_pct  = next_idle;
      rsp_stall_pct = next_stall;
      @(negedge clock);
   endtask

   task automatic send_random_frame();
      logic [7:0]  frame_q[$];
      logic [7:0]  b2;
      int unsigned pick;
      int unsigned hdr_len;
      int unsigned keep;
      int unsigned n;
      pick    = $urandom_range(99);
      b2      = {4'hF, 4'($urandom)};
      hdr_len = b2[0] ? 7 : 9;
      if (pick < 82) begin
         frame_q.push_back(8'hFF);
         frame_q.push_back(b2);
         repeat (hdr_len - 2) frame_q.push_back(8'($urandom));
         if (pick < 70) begin
            n = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 12);
            repeat (n) frame_q.push_back(8'($urandom));
         end else begin
            // cut the frame short inside the header
            keep = $urandom_range(1, hdr_len - 1);
            while (frame_q.size() > keep) void'(frame_q.pop_back());
         end
      end else if (pick < 94) begin
         frame_q.push_back(8'($urandom));
         b2 = 8'($urandom);
         if ({frame_q[0], b2[7:4]} == SYNC_WORD) b2[4] = 1'b0;
         frame_q.push_back(b2);
         n = $urandom_range(0, 8);
         repeat (n) frame_q.push_back(8'($urandom));
      end else begin
         n = $urandom_range(1, 12);
         repeat (n) frame_q.push_back(8'($urandom));
      end
      foreach (frame_q[i])
         send_item(frame_q[i], i == frame_q.size() - 1, ROW_PREDICT, '0);
      frame_cnt++;
   endtask

   always @(negedge clock) begin
      rsp_chan.ready <= (rsp_stall_pct == 0) || ($urandom_range(99) >= rsp_stall_pct);
   end

   always @(posedge clock) begin
      rsp_payload_type got;
      rsp_payload_type want;
      got = rsp_chan.payload;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         rsp_cnt++;
         kind_cnt[got.kind]++;
         if (header_expect_q.size() == 0) begin
            report_mismatch($sformatf("result %0d of kind %0d arrived with nothing expected",
                                      rsp_cnt, got.kind));
         end else begin
            want = header_expect_q.pop_front();
            check_field("kind", 16'(got.kind), 16'(want.kind));
            check_field("last", 16'(got.last), 16'(want.last));
            check_field("data_byte", 16'(got.data_byte), 16'(want.data_byte));
            check_field("profile", 16'(got.profile), 16'(want.profile));
            check_field("sample_rate_index", 16'(got.sample_rate_index),
                        16'(want.sample_rate_index));
            check_field("channel_config", 16'(got.channel_config), 16'(want.channel_config));
            check_field("frame_length", 16'(got.frame_length), 16'(want.frame_length));
            check_field("buffer_fullness", 16'(got.buffer_fullness),
                        16'(want.buffer_fullness));
            check_field("raw_blocks", 16'(got.raw_blocks), 16'(want.raw_blocks));
            check_field("crc_word", got.crc_word, want.crc_word);
            check_field("audio_config", got.audio_config, want.audio_config);
            check_field("misc_bits", 16'(got.misc_bits), 16'(want.misc_bits));
         end
      end
   end

   always @(posedge clock) begin
      cycle_cnt++;
      if (cycle_cnt > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding",
                  cycle_cnt, header_expect_q.size());
         $display("[adts_header_deframer_unit] ERROR");
         $finish;
      end
   end

   initial begin
      rsp_payload_type typed;
      int unsigned     phase_start;
      req_chan.valid   = 1'b0;
      req_chan.payload = '0;
      clear_frame();
      repeat (2) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         typed           = '0;
         typed.kind      = directed_rows[i].kind;
         typed.last      = directed_rows[i].last;
         typed.data_byte = directed_rows[i].data;
         send_item(directed_rows[i].in_byte, directed_rows[i].in_last,
                   directed_rows[i].mode, typed);
      end
      frame_cnt += 6;

      for (int p = 0; p < 4; p++) begin
         drain_results(idle_pct_tbl[p], stall_pct_tbl[p]);
         phase_start = item_cnt;
         while (item_cnt < phase_start + PHASE_ITEMS) send_random_frame();
      end
      drain_results(0, 0);
      repeat (4) @(posedge clock);

      $display("sent %0d frames (%0d bytes handled) across four idle/stall mixes in %0d cycles",
               frame_cnt, item_cnt, cycle_cnt);
      $display("checked %0d results: %0d headers, %0d payload, %0d bad sync, %0d truncated",
               rsp_cnt, kind_cnt[KIND_HEADER], kind_cnt[KIND_PAYLOAD],
               kind_cnt[KIND_BAD_SYNC], kind_cnt[KIND_TRUNCATED]);
      if (err_cnt == 0 && header_expect_q.size() == 0) begin
         $display("[adts_header_deframer_unit] OK");
      end else begin
         $display("[adts_header_deframer_unit] ERROR");
      end
      $finish;
   end

endmodule
